@@ rtl/rrl_pkg.sv @@
`default_nettype none

package rrl_pkg;

    // field widths fixed by the interface
    localparam int TIME_W   = 32;
    localparam int LIMIT_W  = 6;
    localparam int WINDOW_W = 31;
    localparam int RECENT_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // width of the shared add-and-compare datapath
    localparam int SUM_W = TIME_W + 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OFF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 2'd2;

    // "never" codes and register reset values
    localparam logic [LIMIT_W-1:0]  LIMIT_NEVER   = 6'h3f;
    localparam logic [TIME_W-1:0]   HOLD_NEVER    = 32'hffff_ffff;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET  = 31'd60;

    // operation codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    typedef struct packed {
        logic                is_enabled;
        logic                went_disabled;
        logic                went_enabled;
        logic [RECENT_W-1:0] recent_starts;
    } rrl_result_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EVAL = 4'b0100,
        ST_OP   = 4'b1000
    } rrl_state_t;

endpackage

`default_nettype wire

@@ rtl/rrl_if.sv @@
`default_nettype none

// request channel into the limiter
interface rrl_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] now_seconds;

    modport source (output valid, output func, output now_seconds, input ready);
    modport sink   (input valid, input func, input now_seconds, output ready);
endinterface

// result channel out of the limiter
interface rrl_out_if;
    logic       valid;
    logic       ready;
    logic       is_enabled;
    logic       went_disabled;
    logic       went_enabled;
    logic [4:0] recent_starts;

    modport source (output valid, output is_enabled, output went_disabled,
                    output went_enabled, output recent_starts, input ready);
    modport sink   (input valid, input is_enabled, input went_disabled,
                    input went_enabled, input recent_starts, output ready);
endinterface

`default_nettype wire

@@ rtl/rrl_cmp.sv @@
`default_nettype none

// shared unit: x + y against z, x optionally signed, y and z unsigned
module rrl_cmp
    import rrl_pkg::*;
(
    input  wire logic [TIME_W-1:0] x,
    input  wire logic              x_signed,
    input  wire logic [TIME_W-1:0] y,
    input  wire logic [TIME_W-1:0] z,
    output logic                   ge,
    output logic                   le
);

    logic signed [SUM_W-1:0] xs;
    logic signed [SUM_W-1:0] ys;
    logic signed [SUM_W-1:0] zs;
    logic signed [SUM_W-1:0] sum;

    // extend operands, add, compare as signed both ways
    always_comb
    begin
        xs  = $signed({{(SUM_W-TIME_W){x_signed & x[TIME_W-1]}}, x});
        ys  = $signed({{(SUM_W-TIME_W){1'b0}}, y});
        zs  = $signed({{(SUM_W-TIME_W){1'b0}}, z});
        sum = xs + ys;
        ge  = (sum >= zs);
        le  = (sum <= zs);
    end

endmodule

`default_nettype wire

@@ rtl/rrl_stamp_ram.sv @@
`default_nettype none

// start time store: one write port, one registered read port
module rrl_stamp_ram
    import rrl_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [TIME_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output logic      [TIME_W-1:0] rdata
);

    logic [TIME_W-1:0] mem [DEPTH];
    logic [TIME_W-1:0] rdata_reg;

    // write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/respawn_rate_limiter.sv @@
`default_nettype none

// Sliding-window restart limiter. Each request carries a time and an
// operation (record a start, or run a check); the held start times that fell
// out of the window are dropped first, kept ones staying in arrival order.
// A request runs from acceptance to the result register as a sweep over the
// held start times: the store has a single read port and one shared
// add-and-compare unit, so each held stamp is read in a scan state and then
// tested and written back in an eval state; a final scan state ends the sweep
// and the operation state follows. A new request is taken only in the idle
// state, so each request is finished before the next one is accepted.
// in_ch.ready is high only while no request is in work; a finished result
// waits in the output register while the next request is taken, and the
// operation cycle waits for that register to drain. The store
// needs no clearing after reset since only counted entries are ever read.
// Configuration writes are taken at any time but belong in idle periods.
module respawn_rate_limiter
    import rrl_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    rrl_in_if.sink                     in_ch,
    rrl_out_if.source                  out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int CMPW = (CW + 1 > LIMIT_W) ? CW + 1 : LIMIT_W;
    localparam logic [AW-1:0] LAST_PTR = AW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW_DEPTH);

    // configuration registers
    logic [LIMIT_W-1:0]  start_limit_reg;
    logic [TIME_W-1:0]   hold_off_reg;
    logic [WINDOW_W-1:0] window_reg;

    // limiter state
    logic [CW-1:0]     stamp_count_reg, stamp_count_next;
    logic [AW-1:0]     oldest_reg, oldest_next;
    logic              enabled_reg, enabled_next;
    logic [TIME_W-1:0] disabled_since_reg, disabled_since_next;

    // sequencer and sweep
    rrl_state_t        state_reg, state_next;
    logic              func_reg, func_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic [CW-1:0]     kept_reg, kept_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    rrl_result_t result_reg, result_next;

    // store and shared unit connections
    logic              ram_we;
    logic [TIME_W-1:0] ram_wdata;
    logic              ram_re;
    logic [TIME_W-1:0] ram_rdata;
    logic [TIME_W-1:0] cmp_x;
    logic              cmp_x_signed;
    logic [TIME_W-1:0] cmp_y;
    logic              cmp_ge;
    logic              cmp_le;

    logic                   out_free;
    logic signed [CMPW-1:0] lim_ext;
    logic signed [CMPW-1:0] cnt_ext;

    rrl_stamp_ram #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    rrl_cmp u_cmp (
        .x        (cmp_x),
        .x_signed (cmp_x_signed),
        .y        (cmp_y),
        .z        (now_reg),
        .ge       (cmp_ge),
        .le       (cmp_le)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_free    = !out_valid_reg || out_ch.ready;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.is_enabled    = result_reg.is_enabled;
    assign out_ch.went_disabled = result_reg.went_disabled;
    assign out_ch.went_enabled  = result_reg.went_enabled;
    assign out_ch.recent_starts = result_reg.recent_starts;

    assign lim_ext = CMPW'($signed(start_limit_reg));
    assign cnt_ext = $signed(CMPW'(kept_reg));

    // shared unit operand select: window test while sweeping, hold-off otherwise
    always_comb
    begin
        if (state_reg == ST_EVAL)
        begin
            cmp_x        = ram_rdata;
            cmp_x_signed = 1'b0;
            cmp_y        = {1'b0, window_reg};
        end
        else
        begin
            cmp_x        = hold_off_reg;
            cmp_x_signed = 1'b1;
            cmp_y        = disabled_since_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next          = state_reg;
        func_next           = func_reg;
        now_next            = now_reg;
        scan_next           = scan_reg;
        kept_next           = kept_reg;
        rd_ptr_next         = rd_ptr_reg;
        wr_ptr_next         = wr_ptr_reg;
        stamp_count_next    = stamp_count_reg;
        oldest_next         = oldest_reg;
        enabled_next        = enabled_reg;
        disabled_since_next = disabled_since_reg;
        out_valid_next      = out_valid_reg && !out_ch.ready;
        result_next         = result_reg;
        ram_we              = 1'b0;
        ram_wdata           = ram_rdata;
        ram_re              = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    func_next   = in_ch.func;
                    now_next    = in_ch.now_seconds;
                    scan_next   = '0;
                    kept_next   = '0;
                    rd_ptr_next = oldest_reg;
                    wr_ptr_next = oldest_reg;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == stamp_count_reg)
                begin
                    state_next = ST_OP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // keep the stamp if still inside the window, packed in order
                if (cmp_ge)
                begin
                    ram_we      = 1'b1;
                    kept_next   = kept_reg + 1'b1;
                    wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
                end
                rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
                scan_next   = scan_reg + 1'b1;
                state_next  = ST_SCAN;
            end
            ST_OP:
            begin
                if (out_free)
                begin
                    result_next.went_disabled = 1'b0;
                    result_next.went_enabled  = 1'b0;
                    stamp_count_next          = kept_reg;
                    if (func_reg == FUNC_START)
                    begin
                        // append; a full store overwrites its oldest entry
                        ram_we    = 1'b1;
                        ram_wdata = now_reg;
                        if (kept_reg == FULL_CNT)
                        begin
                            oldest_next = (oldest_reg == LAST_PTR) ? '0 : oldest_reg + 1'b1;
                        end
                        else
                        begin
                            stamp_count_next = kept_reg + 1'b1;
                        end
                    end
                    else if (enabled_reg)
                    begin
                        if (start_limit_reg != LIMIT_NEVER && cnt_ext >= lim_ext)
                        begin
                            enabled_next              = 1'b0;
                            disabled_since_next       = now_reg;
                            stamp_count_next          = '0;
                            oldest_next               = '0;
                            result_next.went_disabled = 1'b1;
                        end
                    end
                    else
                    begin
                        // hold-off expired once disabled_since + hold_off <= now
                        if (hold_off_reg != HOLD_NEVER && cmp_le)
                        begin
                            enabled_next             = 1'b1;
                            disabled_since_next      = '0;
                            result_next.went_enabled = 1'b1;
                        end
                    end
                    result_next.is_enabled    = enabled_next;
                    result_next.recent_starts = RECENT_W'(stamp_count_next);
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            stamp_count_reg    <= '0;
            oldest_reg         <= '0;
            enabled_reg        <= 1'b1;
            disabled_since_reg <= '0;
            out_valid_reg      <= 1'b0;
            scan_reg           <= '0;
            kept_reg           <= '0;
            rd_ptr_reg         <= '0;
            wr_ptr_reg         <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            stamp_count_reg    <= stamp_count_next;
            oldest_reg         <= oldest_next;
            enabled_reg        <= enabled_next;
            disabled_since_reg <= disabled_since_next;
            out_valid_reg      <= out_valid_next;
            scan_reg           <= scan_next;
            kept_reg           <= kept_next;
            rd_ptr_reg         <= rd_ptr_next;
            wr_ptr_reg         <= wr_ptr_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        now_reg    <= now_next;
        result_reg <= result_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_limit_reg <= LIMIT_NEVER;
            hold_off_reg    <= HOLD_NEVER;
            window_reg      <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_LIMIT: start_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_HOLD_OFF:    hold_off_reg    <= cfg_data[TIME_W-1:0];
                CFG_WINDOW:      window_reg      <= cfg_data[WINDOW_W-1:0];
                default:
                begin
                    start_limit_reg <= start_limit_reg;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
